// ----- rtl/bra_pkg.sv -----
`timescale 1ns / 1ps
// Shared definitions for the block run allocator: field widths, mark and
// status codes, sequencer states. No dependencies.
package bra_pkg;

   // Field widths of the request, result and register
   localparam int unsigned MODE_W   = 1;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned INDEX_W  = 10;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned START_W  = 10;
   localparam int unsigned ACTIVE_W = 11;
   localparam int unsigned MARK_W   = 2;

   // Default heap size in blocks and register reset value
   localparam int unsigned MAX_BLOCKS_DEF = 1024;
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 11'd1024;

   // Request modes
   localparam logic [MODE_W-1:0] MODE_ALLOC = 1'b0;
   localparam logic [MODE_W-1:0] MODE_FREE  = 1'b1;

   // Per-block marks
   localparam logic [MARK_W-1:0] MARK_FREE = 2'd0;
   localparam logic [MARK_W-1:0] MARK_USED = 2'd1;
   localparam logic [MARK_W-1:0] MARK_END  = 2'd2;

   // Result status codes
   localparam logic [STATUS_W-1:0] STATUS_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_ALLOC_FAIL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_HIT_FREE   = 2'd3;

   // Sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_WALK,
      ST_MARK,
      ST_REPLY
   } state_type;

endpackage

// ----- rtl/bra_ram.sv -----
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No dependencies.
module bra_ram #(
   parameter int unsigned WIDTH = 2,
   parameter int unsigned DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read; a read of the address being written returns old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/block_run_allocator.sv -----
`timescale 1ns / 1ps
// First-fit contiguous block allocator. Uses bra_pkg and bra_ram.
//
// The block keeps a 2-bit mark per heap block in one RAM and serves one
// request at a time. After reset it clears all MAX_BLOCKS entries of the
// mark RAM, one entry per cycle, and holds req_stall high meanwhile. An
// allocate scans the marks from block 0 upward, one block per cycle through
// the RAM read port, then writes the found run one block per cycle. A free
// walks from block_index one block per cycle, reading ahead while clearing
// behind. A rejected request (zero or oversize count, index out of range)
// goes straight to the reply. The result sits in an output register, so a
// new request is taken while an earlier result still waits on rsp_stall.
// csr_ready is always high; write active_blocks only while no request is in
// progress.
module block_run_allocator #(
   parameter int unsigned MAX_BLOCKS = bra_pkg::MAX_BLOCKS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [bra_pkg::MODE_W-1:0]     req_mode,
   input  logic [bra_pkg::COUNT_W-1:0]    req_block_count,
   input  logic [bra_pkg::INDEX_W-1:0]    req_block_index,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [bra_pkg::STATUS_W-1:0]   rsp_status,
   output logic [bra_pkg::START_W-1:0]    rsp_start_index,
   // register write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [bra_pkg::ACTIVE_W-1:0]   csr_active_blocks
);

   import bra_pkg::*;

   localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
   localparam int unsigned CNT_W = $clog2(MAX_BLOCKS + 1);
   localparam int unsigned W     = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   state_type            state_ff, state_in;
   logic [W-1:0]         ptr_ff, ptr_in;
   logic [W-1:0]         chk_ff, chk_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [W-1:0]         run_ff, run_in;
   logic [W-1:0]         want_ff, want_in;
   logic [STATUS_W-1:0]  res_status_ff, res_status_in;
   logic [START_W-1:0]   res_start_ff, res_start_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [START_W-1:0]   rsp_start_ff, rsp_start_in;
   logic [ACTIVE_W-1:0]  active_ff;

   logic [W-1:0]         eff;
   logic [W-1:0]         active_ext;
   logic [W-1:0]         run_nx;
   logic [W-1:0]         first;
   logic                 rd_en;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [MARK_W-1:0]    wr_data;
   logic [MARK_W-1:0]    rd_data;

   // Hold the active block register
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
      end else if (csr_valid && csr_ready) begin
         active_ff <= csr_active_blocks;
      end
   end

   assign csr_ready = 1'b1;

   // Effective block count: register clamped to the heap size
   assign active_ext = W'(active_ff);
   assign eff        = (active_ext > W'(MAX_BLOCKS)) ? W'(MAX_BLOCKS) : active_ext;

   // Mark store
   bra_ram #(
      .WIDTH (MARK_W),
      .DEPTH (MAX_BLOCKS)
   ) u_marks (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (ptr_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   // Run length and run start as seen by the block now arriving from the RAM
   assign run_nx = (rd_data == MARK_FREE) ? (run_ff + W'(1)) : '0;
   assign first  = chk_ff + W'(1) - want_ff;

   // Sequencer registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         ptr_ff       <= '0;
         chk_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         chk_vld_ff   <= chk_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_ff        <= chk_in;
      run_ff        <= run_in;
      want_ff       <= want_in;
      res_status_ff <= res_status_in;
      res_start_ff  <= res_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_start_ff  <= rsp_start_in;
   end

   // Next state, RAM control and result
   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      chk_in        = chk_ff;
      chk_vld_in    = chk_vld_ff;
      run_in        = run_ff;
      want_in       = want_ff;
      res_status_in = res_status_ff;
      res_start_in  = res_start_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_start_in  = rsp_start_ff;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = ptr_ff[IDX_W-1:0];
      wr_data       = MARK_FREE;
      req_stall     = 1'b1;

      case (state_ff)
         // Sweep the mark store to free after reset
         ST_CLEAR: begin
            wr_en  = 1'b1;
            ptr_in = ptr_ff + W'(1);
            if (ptr_ff == W'(MAX_BLOCKS - 1)) begin
               state_in = ST_IDLE;
            end
         end

         // Take a request; reject bad ones at once
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ptr_in       = '0;
               chk_vld_in   = 1'b0;
               run_in       = '0;
               want_in      = W'(req_block_count);
               res_start_in = '0;
               if (req_mode == MODE_ALLOC) begin
                  if (req_block_count == '0 || W'(req_block_count) > eff) begin
                     res_status_in = STATUS_ALLOC_FAIL;
                     state_in      = ST_REPLY;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  if (W'(req_block_index) >= eff) begin
                     res_status_in = STATUS_RANGE;
                     state_in      = ST_REPLY;
                  end else begin
                     ptr_in   = W'(req_block_index);
                     state_in = ST_WALK;
                  end
               end
            end
         end

         // Read ahead one block per cycle; check the block read last cycle
         ST_SCAN: begin
            chk_vld_in = 1'b0;
            if (ptr_ff < eff) begin
               rd_en      = 1'b1;
               ptr_in     = ptr_ff + W'(1);
               chk_in     = ptr_ff;
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff) begin
               run_in = run_nx;
               if (run_nx == want_ff) begin
                  // Run found: chk_ff holds its last block
                  state_in     = ST_MARK;
                  ptr_in       = first;
                  chk_in       = chk_ff;
                  chk_vld_in   = 1'b0;
                  res_start_in = first[START_W-1:0];
               end else if (chk_ff + W'(1) == eff) begin
                  state_in      = ST_REPLY;
                  chk_vld_in    = 1'b0;
                  res_status_in = STATUS_ALLOC_FAIL;
                  res_start_in  = '0;
               end
            end
         end

         // Write the run: used blocks, end mark on the last one
         ST_MARK: begin
            wr_en   = 1'b1;
            wr_data = (ptr_ff == chk_ff) ? MARK_END : MARK_USED;
            ptr_in  = ptr_ff + W'(1);
            if (ptr_ff == chk_ff) begin
               res_status_in = STATUS_OK;
               state_in      = ST_REPLY;
            end
         end

         // Read ahead, clear behind, stop at an end, a free block or the heap edge
         ST_WALK: begin
            chk_vld_in = 1'b0;
            if (ptr_ff < eff) begin
               rd_en      = 1'b1;
               ptr_in     = ptr_ff + W'(1);
               chk_in     = ptr_ff;
               chk_vld_in = 1'b1;
            end
            if (chk_vld_ff) begin
               if (rd_data == MARK_FREE) begin
                  state_in      = ST_REPLY;
                  chk_vld_in    = 1'b0;
                  res_status_in = STATUS_HIT_FREE;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = chk_ff[IDX_W-1:0];
                  wr_data = MARK_FREE;
                  if (rd_data == MARK_END) begin
                     state_in      = ST_REPLY;
                     chk_vld_in    = 1'b0;
                     res_status_in = STATUS_OK;
                  end else if (chk_ff + W'(1) == eff) begin
                     state_in      = ST_REPLY;
                     chk_vld_in    = 1'b0;
                     res_status_in = STATUS_HIT_FREE;
                  end
               end
            end
         end

         // Move the result into the output register once it is free
         ST_REPLY: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_start_in  = res_start_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_start_index = rsp_start_ff;

   // A start index is reported only with a successful result
   a_start_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_start_index == '0))
      else $error("nonzero start index on a failed result");

   // The mark store is written only while clearing, marking or walking
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_CLEAR || state_ff == ST_MARK || state_ff == ST_WALK))
      else $error("mark store written outside a write phase");

   // Marking never runs past the last block of the found run
   a_mark_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MARK) |-> (ptr_ff <= chk_ff && $past(state_ff) != ST_IDLE))
      else $error("marking pointer beyond end of run");

endmodule

// ----- tb/block_run_allocator_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for block_run_allocator: directed corner cases, then
// random allocate/free traffic over a series of heap sizes, with random
// idling on both channels. Depends on bra_pkg and the allocator RTL.
module block_run_allocator_tb;
   import bra_pkg::*;

   localparam int unsigned HEAP_MAX        = MAX_BLOCKS_DEF;
   localparam int unsigned IDLE_LIMIT      = 20000;
   localparam int unsigned ITEMS_PER_PHASE = 58;
   localparam int unsigned REPORT_MAX      = 10;

   // Mirror of the mark store and the heap size; holds expected results in
   // request order and compares each returned item against the oldest one.
   class alloc_scoreboard;
      logic [MARK_W-1:0]   marks [HEAP_MAX];
      logic [ACTIVE_W-1:0] active;
      logic [STATUS_W-1:0] want_status [$];
      logic [START_W-1:0]  want_start [$];
      int unsigned failures, results, requests, cfg_writes;
      int unsigned status_seen [4];

      function new();
         foreach (marks[i]) marks[i] = MARK_FREE;
         foreach (status_seen[i]) status_seen[i] = 0;
         active     = ACTIVE_RESET;
         failures   = 0;
         results    = 0;
         requests   = 0;
         cfg_writes = 0;
      endfunction

      function int unsigned heap_size();
         return (active > HEAP_MAX) ? HEAP_MAX : int'(active);
      endfunction

      function int unsigned pending();
         return want_status.size();
      endfunction

      function void set_active(input logic [ACTIVE_W-1:0] value);
         active = value;
         cfg_writes++;
      endfunction

      // A block that starts an allocated run
      function bit run_head(input int unsigned i);
         if (marks[i] == MARK_FREE) return 1'b0;
         return (i == 0) || (marks[i-1] == MARK_FREE) || (marks[i-1] == MARK_END);
      endfunction

      // Apply one accepted request to the mirror and queue its result
      function void note_request(input logic [MODE_W-1:0]  mode,
                                 input logic [COUNT_W-1:0] count,
                                 input logic [INDEX_W-1:0] index);
         int unsigned n, run, first;
         logic [MARK_W-1:0]   m;
         logic [STATUS_W-1:0] st;
         logic [START_W-1:0]  start;
         n     = heap_size();
         start = '0;
         requests++;
         if (mode == MODE_ALLOC) begin
            st = STATUS_ALLOC_FAIL;
            if (count != 0 && count <= n) begin
               run = 0;
               // first fit: stop at the first run long enough
               for (int i = 0; i < n; i++) begin
                  if (marks[i] == MARK_FREE) run++;
                  else run = 0;
                  if (run == count) begin
                     first = i + 1 - run;
                     for (int j = first; j < i; j++) marks[j] = MARK_USED;
                     marks[i] = MARK_END;
                     start    = START_W'(first);
                     st       = STATUS_OK;
                     break;
                  end
               end
            end
         end else if (index >= n) begin
            st = STATUS_RANGE;
         end else begin
            // walk until the end mark; a free block or the heap edge stops it
            st = STATUS_HIT_FREE;
            for (int i = index; i < n; i++) begin
               m = marks[i];
               if (m == MARK_FREE) break;
               marks[i] = MARK_FREE;
               if (m == MARK_END) begin
                  st = STATUS_OK;
                  break;
               end
            end
         end
         want_status.push_back(st);
         want_start.push_back(start);
      endfunction

      // Compare one returned item with the oldest expectation
      function void check_result(input logic [STATUS_W-1:0] status,
                                 input logic [START_W-1:0]  start);
         logic [STATUS_W-1:0] st;
         logic [START_W-1:0]  sx;
         results++;
         status_seen[status]++;
         if (want_status.size() == 0) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("%0t: unexpected result status=%0d start=%0d", $time, status, start);
            return;
         end
         st = want_status.pop_front();
         sx = want_start.pop_front();
         if (status !== st || start !== sx) begin
            failures++;
            if (failures <= REPORT_MAX)
               $display("%0t: result %0d mismatch: status exp %0d got %0d, start exp %0d got %0d",
                        $time, results, st, status, sx, start);
         end
      endfunction
   endclass

   logic                clock           = 1'b0;
   logic                reset           = 1'b1;
   logic                req_valid       = 1'b0;
   logic                req_stall;
   logic [MODE_W-1:0]   req_mode        = MODE_ALLOC;
   logic [COUNT_W-1:0]  req_block_count = '0;
   logic [INDEX_W-1:0]  req_block_index = '0;
   logic                rsp_valid;
   logic                rsp_stall       = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [START_W-1:0]  rsp_start_index;
   logic                csr_valid         = 1'b0;
   logic                csr_ready;
   logic [ACTIVE_W-1:0] csr_active_blocks = ACTIVE_RESET;

   alloc_scoreboard sb;
   bit              calm         = 1'b0;
   int unsigned     idle_cycles  = 0;
   int unsigned     stall_left   = 0;
   int unsigned     heap_sizes [10] = '{1024, 16, 1, 64, 2047, 0, 8, 200, 2, 40};

   block_run_allocator #(.MAX_BLOCKS(HEAP_MAX)) DUT (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_block_count   (req_block_count),
      .req_block_index   (req_block_index),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_start_index   (rsp_start_index),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_active_blocks (csr_active_blocks)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle length: mostly none or short, a few long; none while calm
   function automatic int unsigned pause_len();
      int unsigned r;
      r = $urandom_range(99);
      if (calm || r < 50) return 0;
      if (r < 85) return $urandom_range(3, 1);
      if (r < 97) return $urandom_range(10, 4);
      return $urandom_range(60, 20);
   endfunction

   // Stall the result side at random
   always @(posedge clock) begin
      if (stall_left != 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(99) < 25) begin
         stall_left = pause_len();
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check every accepted result
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_status, rsp_start_index);
   end

   // Watchdog: end the run when no handshake happens for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == IDLE_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                  IDLE_LIMIT, sb.pending());
         $display("CHECK FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Present one request item and hold it until accepted
   task automatic send(input logic [MODE_W-1:0]  mode,
                       input logic [COUNT_W-1:0] count,
                       input logic [INDEX_W-1:0] index);
      int unsigned gap;
      gap = pause_len();
      if ($urandom_range(31) == 0) calm = !calm;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_block_count <= count;
      req_block_index <= index;
      do @(posedge clock); while (req_stall);
      sb.note_request(mode, count, index);
   endtask

   // Drop valid and wait for every outstanding result
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Change the heap size while the block is idle
   task automatic write_active(input logic [ACTIVE_W-1:0] value);
      drain();
      csr_valid         <= 1'b1;
      csr_active_blocks <= value;
      do @(posedge clock); while (!csr_ready);
      sb.set_active(value);
      csr_valid <= 1'b0;
   endtask

   // Random request: mostly small allocations and frees of live runs,
   // with some oversize, zero, out-of-range and mid-run noise
   task automatic random_item(output logic [MODE_W-1:0]  mode,
                              output logic [COUNT_W-1:0] count,
                              output logic [INDEX_W-1:0] index);
      int unsigned n, sel;
      int unsigned heads [$];
      n     = sb.heap_size();
      sel   = $urandom_range(99);
      count = COUNT_W'($urandom());
      index = INDEX_W'($urandom());
      if ($urandom_range(99) < 55) begin
         mode = MODE_ALLOC;
         if (sel < 70) count = COUNT_W'($urandom_range(8, 1));
         else if (sel < 82 && n != 0) count = COUNT_W'($urandom_range(n, 1));
         else if (sel < 88) count = '0;
         else if (sel < 94) count = COUNT_W'(n + $urandom_range(4, 1));
      end else begin
         mode = MODE_FREE;
         for (int i = 0; i < n; i++)
            if (sb.run_head(i)) heads.push_back(i);
         if (sel < 70 && heads.size() != 0)
            index = INDEX_W'(heads[$urandom_range(heads.size() - 1)]);
         else if (sel < 85 && n != 0)
            index = INDEX_W'($urandom_range(n - 1));
      end
   endtask

   initial begin
      logic [MODE_W-1:0]  m;
      logic [COUNT_W-1:0] c;
      logic [INDEX_W-1:0] x;
      sb = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full heap: rejects, first fit, partial and complete frees
      write_active(ACTIVE_RESET);
      send(MODE_ALLOC, 11'd0,    10'd0);
      send(MODE_ALLOC, 11'd1025, 10'd0);
      send(MODE_ALLOC, 11'd2047, 10'd1023);
      send(MODE_ALLOC, 11'd1,    10'd0);
      send(MODE_ALLOC, 11'd3,    10'd0);
      send(MODE_ALLOC, 11'd2,    10'd0);
      send(MODE_FREE,  11'd0,    10'd1);
      send(MODE_ALLOC, 11'd2,    10'd0);
      send(MODE_FREE,  11'd0,    10'd3);
      send(MODE_FREE,  11'd2047, 10'd1023);
      send(MODE_FREE,  11'd0,    10'd2);
      send(MODE_FREE,  11'd0,    10'd1);
      send(MODE_FREE,  11'd0,    10'd0);
      send(MODE_FREE,  11'd0,    10'd4);
      send(MODE_ALLOC, 11'd1024, 10'd0);
      send(MODE_ALLOC, 11'd1,    10'd0);
      send(MODE_FREE,  11'd0,    10'd0);

      // Shrunk heap: walk off the edge, out of range, zero and oversize size
      write_active(11'd16);
      send(MODE_ALLOC, 11'd12, 10'd0);
      write_active(11'd6);
      send(MODE_FREE,  11'd0, 10'd0);
      send(MODE_ALLOC, 11'd6, 10'd0);
      send(MODE_FREE,  11'd0, 10'd6);
      write_active(11'd0);
      send(MODE_ALLOC, 11'd1, 10'd0);
      send(MODE_FREE,  11'd0, 10'd0);
      write_active(11'd2047);
      send(MODE_FREE,  11'd0, 10'd6);
      send(MODE_FREE,  11'd0, 10'd0);
      write_active(11'd1);
      send(MODE_ALLOC, 11'd1, 10'd0);
      send(MODE_ALLOC, 11'd1, 10'd0);
      send(MODE_FREE,  11'd0, 10'd0);

      // Random traffic over a series of heap sizes; marks carry across
      foreach (heap_sizes[p]) begin
         write_active(ACTIVE_W'(heap_sizes[p]));
         repeat (ITEMS_PER_PHASE) begin
            random_item(m, c, x);
            send(m, c, x);
         end
      end

      drain();
      repeat (64) @(posedge clock);
      $display("Covered %0d requests and %0d results across %0d heap-size writes.",
               sb.requests, sb.results, sb.cfg_writes);
      $display("Statuses seen: ok %0d, alloc fail %0d, range %0d, hit free %0d; %0d failures.",
               sb.status_seen[STATUS_OK], sb.status_seen[STATUS_ALLOC_FAIL],
               sb.status_seen[STATUS_RANGE], sb.status_seen[STATUS_HIT_FREE], sb.failures);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
